// ===== sv/sfh_pkg.sv =====
// ----------------------------------------------------------------------------
// sfh_pkg
// shared types and constants of the spgemm row flop histogram
// ----------------------------------------------------------------------------
package sfh_pkg;

   localparam int ACT_W     = 3;
   localparam int IDX_W     = 11;
   localparam int PTR_W     = 32;
   localparam int CNT_W     = 32;
   localparam int ACC_W     = 48;
   localparam int BKT_OUT_W = 5;
   localparam int NB_W      = 6;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 88;

   localparam logic [NB_W-1:0] NUM_BUCKETS_RESET = 6'd30;

   // csr word index
   localparam logic REG_NUM_BUCKETS = 1'b0;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD_PTR = 3'd0,
      ACT_NONZERO  = 3'd1,
      ACT_EMPTY    = 3'd2,
      ACT_READ_BIN = 3'd3,
      ACT_CLEAR    = 3'd4
   } action_type;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_PTR_LO  = 8'b0000_0010,
      ST_PTR_HI  = 8'b0000_0100,
      ST_ACCUM   = 8'b0000_1000,
      ST_BKT_SEL = 8'b0001_0000,
      ST_CNT_UPD = 8'b0010_0000,
      ST_BIN_RD  = 8'b0100_0000,
      ST_EMIT    = 8'b1000_0000
   } state_type;

endpackage

// ===== sv/sfh_ram.sv =====
// ----------------------------------------------------------------------------
// sfh_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module sfh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/spgemm_row_flops_histogram.sv =====
// ----------------------------------------------------------------------------
// spgemm_row_flops_histogram
// per-row flop count of a sparse product, binned into power-of-two buckets
// ----------------------------------------------------------------------------
// cycles through ptr_lo and ptr_hi for a nonzero with a valid column (two reads on the
// single read port of the pointer ram), then accum; a column outside B goes straight to
// accum. a closing nonzero or empty row then runs bkt_sel, cnt_upd (count read-modify-write)
// and emit; a bin read runs bin_rd and emit; pointer load, clear and unused actions finish
// in idle, the only state taking requests. a result awaiting transfer holds the next one.
// reset clears accumulator and bucket valid bits, sets num_buckets to 30; pointers undefined
module spgemm_row_flops_histogram #(
   parameter int B_ROWS      = 1024,
   parameter int MAX_BUCKETS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [10:0] index, [42:11] pointer_value, zero fill to 48
   input  logic [sfh_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [2:0] action
   input  logic [sfh_pkg::ACT_W-1:0]          req_tuser,
   input  logic                               req_tlast,
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [4:0] bucket, [36:5] bin_count, [84:37] flop_total, zero fill to 88
   output logic [sfh_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] is_row_result
   output logic [0:0]                         rsp_tuser,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int PA  = $clog2(B_ROWS + 1);
   localparam int BA  = $clog2(MAX_BUCKETS);
   localparam int NBW = $clog2(MAX_BUCKETS + 1);

   localparam int ACC_W = sfh_pkg::ACC_W;
   localparam int CNT_W = sfh_pkg::CNT_W;
   localparam int PTR_W = sfh_pkg::PTR_W;

   // request fields
   logic [sfh_pkg::IDX_W-1:0] req_index;
   logic [PTR_W-1:0]          req_pointer;
   logic [31:0]               idx32;

   assign req_index   = req_tdata[sfh_pkg::IDX_W-1:0];
   assign req_pointer = req_tdata[sfh_pkg::IDX_W +: PTR_W];
   assign idx32       = 32'(req_index);

   // state
   sfh_pkg::state_type      state_ff, state_in;
   logic [sfh_pkg::NB_W-1:0] num_buckets_ff, num_buckets_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [MAX_BUCKETS-1:0]  vld_ff, vld_in;
   logic [PA-1:0]           pidx_ff, pidx_in;
   logic                    last_ff, last_in;
   logic [PTR_W-1:0]        lo_ff, lo_in;
   logic [PTR_W-1:0]        len_ff, len_in;
   logic [ACC_W-1:0]        total_ff, total_in;
   logic [BA-1:0]           bkt_ff, bkt_in;
   logic                    bin_hit_ff, bin_hit_in;
   logic [sfh_pkg::BKT_OUT_W-1:0] obkt_ff, obkt_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    row_ff, row_in;

   logic                    out_valid_ff, out_valid_in;
   logic [sfh_pkg::BKT_OUT_W-1:0] out_bkt_ff, out_bkt_in;
   logic [CNT_W-1:0]        out_cnt_ff, out_cnt_in;
   logic [ACC_W-1:0]        out_flops_ff, out_flops_in;
   logic                    out_row_ff, out_row_in;

   // memory ports
   logic             ptr_wr_en, ptr_rd_en;
   logic [PA-1:0]    ptr_wr_addr, ptr_rd_addr;
   logic [PTR_W-1:0] ptr_rd_data;
   logic             cnt_wr_en, cnt_rd_en;
   logic [BA-1:0]    cnt_rd_addr;
   logic [CNT_W-1:0] cnt_wr_data, cnt_rd_data;

   // configuration
   logic             csr_wr;
   logic [NBW-1:0]   nb_raw, nb_eff;

   // datapath helpers
   logic             accept;
   logic             emit_go;
   logic [ACC_W:0]   acc_sum;
   logic [ACC_W-1:0] acc_sat;
   logic [CNT_W-1:0] cnt_old;
   logic [NBW-1:0]   bkt_sel;
   logic             bkt_found;

   sfh_ram #(.WIDTH(PTR_W), .DEPTH(B_ROWS + 1)) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_wr_en),
      .wr_addr (ptr_wr_addr),
      .wr_data (req_pointer),
      .rd_en   (ptr_rd_en),
      .rd_addr (ptr_rd_addr),
      .rd_data (ptr_rd_data)
   );

   sfh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BUCKETS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (bkt_ff),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == sfh_pkg::REG_NUM_BUCKETS);
   assign csr_prdata = (csr_paddr[2] == sfh_pkg::REG_NUM_BUCKETS)
                       ? 32'(num_buckets_ff) : 32'd0;
   assign num_buckets_in = csr_wr ? csr_pwdata[sfh_pkg::NB_W-1:0] : num_buckets_ff;

   // effective bucket count, clamped to 2..MAX_BUCKETS
   always_comb begin
      nb_raw = NBW'(num_buckets_ff);
      if (32'(num_buckets_ff) < 32'd2) begin
         nb_eff = NBW'(2);
      end else if (32'(num_buckets_ff) > 32'(MAX_BUCKETS)) begin
         nb_eff = NBW'(MAX_BUCKETS);
      end else begin
         nb_eff = nb_raw;
      end
   end

   // first bucket i below the last with total <= 2^i
   always_comb begin
      bkt_sel   = nb_eff - NBW'(1);
      bkt_found = 1'b0;
      for (int i = 0; i < MAX_BUCKETS - 1; i++) begin
         if (!bkt_found && (32'(i + 1) < 32'(nb_eff))
             && (64'(total_ff) <= (64'd1 << i))) begin
            bkt_sel   = NBW'(i);
            bkt_found = 1'b1;
         end
      end
   end

   assign accept  = req_tvalid && req_tready;
   assign emit_go = (state_ff == sfh_pkg::ST_EMIT) && (!out_valid_ff || rsp_tready);

   assign acc_sum = {1'b0, acc_ff} + (ACC_W + 1)'(len_ff);
   assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
   assign cnt_old = vld_ff[bkt_ff] ? cnt_rd_data : '0;

   assign req_tready = (state_ff == sfh_pkg::ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      vld_in      = vld_ff;
      pidx_in     = pidx_ff;
      last_in     = last_ff;
      lo_in       = lo_ff;
      len_in      = len_ff;
      total_in    = total_ff;
      bkt_in      = bkt_ff;
      bin_hit_in  = bin_hit_ff;
      obkt_in     = obkt_ff;
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      ptr_wr_en   = 1'b0;
      ptr_wr_addr = idx32[PA-1:0];
      ptr_rd_en   = 1'b0;
      ptr_rd_addr = idx32[PA-1:0];
      cnt_wr_en   = 1'b0;
      cnt_wr_data = (cnt_old == {CNT_W{1'b1}}) ? cnt_old : cnt_old + CNT_W'(1);
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = idx32[BA-1:0];

      unique case (state_ff)
         sfh_pkg::ST_IDLE: begin
            if (accept) begin
               pidx_in = idx32[PA-1:0];
               last_in = req_tlast;
               case (sfh_pkg::action_type'(req_tuser))
                  sfh_pkg::ACT_LOAD_PTR: begin
                     ptr_wr_en = (idx32 <= 32'(B_ROWS));
                  end
                  sfh_pkg::ACT_NONZERO: begin
                     if (idx32 < 32'(B_ROWS)) begin
                        ptr_rd_en = 1'b1;
                        state_in  = sfh_pkg::ST_PTR_LO;
                     end else begin
                        // column outside B contributes nothing
                        len_in   = '0;
                        state_in = sfh_pkg::ST_ACCUM;
                     end
                  end
                  sfh_pkg::ACT_EMPTY: begin
                     total_in = '0;
                     state_in = sfh_pkg::ST_BKT_SEL;
                  end
                  sfh_pkg::ACT_READ_BIN: begin
                     bin_hit_in = (idx32 < 32'(MAX_BUCKETS));
                     bkt_in     = idx32[BA-1:0];
                     obkt_in    = req_index[sfh_pkg::BKT_OUT_W-1:0];
                     cnt_rd_en  = 1'b1;
                     total_in   = '0;
                     row_in     = 1'b0;
                     state_in   = sfh_pkg::ST_BIN_RD;
                  end
                  sfh_pkg::ACT_CLEAR: begin
                     vld_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sfh_pkg::ST_PTR_LO: begin
            lo_in       = ptr_rd_data;
            ptr_rd_en   = 1'b1;
            ptr_rd_addr = pidx_ff + PA'(1);
            state_in    = sfh_pkg::ST_PTR_HI;
         end
         sfh_pkg::ST_PTR_HI: begin
            len_in   = (ptr_rd_data > lo_ff) ? ptr_rd_data - lo_ff : '0;
            state_in = sfh_pkg::ST_ACCUM;
         end
         sfh_pkg::ST_ACCUM: begin
            if (last_ff) begin
               total_in = acc_sat;
               acc_in   = '0;
               state_in = sfh_pkg::ST_BKT_SEL;
            end else begin
               acc_in   = acc_sat;
               state_in = sfh_pkg::ST_IDLE;
            end
         end
         sfh_pkg::ST_BKT_SEL: begin
            bkt_in      = BA'(bkt_sel);
            obkt_in     = sfh_pkg::BKT_OUT_W'(bkt_sel);
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = BA'(bkt_sel);
            row_in      = 1'b1;
            state_in    = sfh_pkg::ST_CNT_UPD;
         end
         sfh_pkg::ST_CNT_UPD: begin
            cnt_wr_en      = 1'b1;
            cnt_in         = cnt_wr_data;
            vld_in[bkt_ff] = 1'b1;
            state_in       = sfh_pkg::ST_EMIT;
         end
         sfh_pkg::ST_BIN_RD: begin
            cnt_in   = bin_hit_ff ? cnt_old : '0;
            state_in = sfh_pkg::ST_EMIT;
         end
         sfh_pkg::ST_EMIT: begin
            if (emit_go) begin
               state_in = sfh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfh_pkg::ST_IDLE;
         end
      endcase
   end

   // output register, holds a finished result until transfer
   always_comb begin
      out_valid_in = out_valid_ff;
      out_bkt_in   = out_bkt_ff;
      out_cnt_in   = out_cnt_ff;
      out_flops_in = out_flops_ff;
      out_row_in   = out_row_ff;
      if (emit_go) begin
         out_valid_in = 1'b1;
         out_bkt_in   = obkt_ff;
         out_cnt_in   = cnt_ff;
         out_flops_in = total_ff;
         out_row_in   = row_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sfh_pkg::ST_IDLE;
         num_buckets_ff <= sfh_pkg::NUM_BUCKETS_RESET;
         acc_ff         <= '0;
         vld_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         num_buckets_ff <= num_buckets_in;
         acc_ff         <= acc_in;
         vld_ff         <= vld_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      len_ff       <= len_in;
      total_ff     <= total_in;
      bkt_ff       <= bkt_in;
      bin_hit_ff   <= bin_hit_in;
      obkt_ff      <= obkt_in;
      cnt_ff       <= cnt_in;
      row_ff       <= row_in;
      out_bkt_ff   <= out_bkt_in;
      out_cnt_ff   <= out_cnt_in;
      out_flops_ff <= out_flops_in;
      out_row_ff   <= out_row_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = sfh_pkg::RSP_TDATA_W'({out_flops_ff, out_cnt_ff, out_bkt_ff});
   assign rsp_tuser  = out_row_ff;

endmodule

// ===== sv/sfh_checker.sv =====
// ----------------------------------------------------------------------------
// sfh_checker
// port-level checks on the result stream of the flop histogram
// ----------------------------------------------------------------------------
module sfh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // bin reads carry no flop total
   a_read_flops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[84:37] == 48'd0)
      else $error("bin read with nonzero flops");

   // a row result just incremented its bin
   a_row_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[36:5] != 32'd0)
      else $error("row result with zero count");

   // totals of zero or one always land in bucket zero
   a_small_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tdata[84:38] == 47'd0 |-> rsp_tdata[4:0] == 5'd0)
      else $error("small total outside bucket zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind spgemm_row_flops_histogram sfh_checker u_sfh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
